### rtl/wcm_pkg.sv
// Shared types and codes of the word concatenation matcher.
// No dependencies; every other file of the block imports this package.
package wcm_pkg;

    typedef logic [1:0]  t_cmd;
    typedef logic [2:0]  t_slot;
    typedef logic [63:0] t_word;
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_pos;
    typedef logic [3:0]  t_cfg;
    typedef logic [0:0]  t_cfg_idx;
    typedef logic [3:0]  t_wl;

    // Request commands
    localparam t_cmd CMD_LOAD  = 2'd0;
    localparam t_cmd CMD_TEXT  = 2'd1;
    localparam t_cmd CMD_START = 2'd2;

    // Configuration register indexes
    localparam t_cfg_idx REG_WORD_LENGTH = 1'b0;
    localparam t_cfg_idx REG_WORD_COUNT  = 1'b1;

    // Sequencer controls broadcast to the window cells and the matcher
    typedef struct packed {
        logic shift;  // push one text byte into the history line
        logic load;   // copy the updated history into the scratch line
        logic step;   // advance the scratch line by one word, consume one slot
        t_wl  wl;     // clamped word length in bytes
    } t_seq_ctrl;

endpackage

### rtl/wcm_req_if.sv
// Request channel of the word concatenation matcher: valid/ready plus fields.
// Depends on wcm_pkg.
interface wcm_req_if import wcm_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cmd  cmd;
    t_slot word_slot;
    t_word word_chars;
    t_byte text_char;

    modport source (output valid, cmd, word_slot, word_chars, text_char, input ready);
    modport sink   (input valid, cmd, word_slot, word_chars, text_char, output ready);
endinterface

### rtl/wcm_rsp_if.sv
// Result channel of the word concatenation matcher: valid/ready plus match start.
// Depends on wcm_pkg.
interface wcm_rsp_if import wcm_pkg::*; ();
    logic valid;
    logic ready;
    t_pos match_start;

    modport source (output valid, match_start, input ready);
    modport sink   (input valid, match_start, output ready);
endinterface

### rtl/word_concatenation_matcher_top.sv
// Top level of the word concatenation matcher: sequencer, cell chain, matcher.
// Depends on wcm_pkg, wcm_req_if, wcm_rsp_if, wcm_cell and wcm_match.
//
//  Channel   Dir  Handshake              Payload
//  i_req     in   valid/ready            cmd, word_slot, word_chars, text_char
//  o_rsp     out  valid/ready            match_start
//  cfg       in   i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// Load, start and unused requests leave the sequencer idle. A text request shifts in
// one byte and, once the window is full, starts a scan of one step per window word
// (word_count, up to MAX_WORDS) through cell 0's head with the shared slot comparators,
// then posts a hit. A scan ends early at the first unpaired word. Reset clears the
// sequencer, the position and byte counts, and the result register; dictionary and
// window contents are not cleared.
// A held result stalls only the posting step; the next request waits in idle.
module word_concatenation_matcher_top import wcm_pkg::*; #(
    parameter int MAX_WORDS    = 8,
    parameter int MAX_WORD_LEN = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wcm_req_if.sink          i_req,
    wcm_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  t_cfg             i_cfg_data
);

    localparam int WIN    = MAX_WORDS * MAX_WORD_LEN;
    localparam int SEEN_W = $clog2(WIN + 1);
    localparam int WC_W   = $clog2(MAX_WORDS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        r_state;
    t_cfg              r_word_length;
    t_cfg              r_word_count;
    t_pos              r_pos;
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    logic [WC_W-1:0]   r_step;
    t_pos              r_start;
    logic              r_ov;
    t_pos              r_match_start;

    t_wl               wl;
    logic [WC_W-1:0]   wc;
    logic [SEEN_W-1:0] total;
    logic              accept;
    logic              text_req;
    logic              load_req;
    logic              window_full;
    logic              found;
    logic              post;
    t_seq_ctrl         ctrl;

    logic [MAX_WORD_LEN-1:0][7:0] scr_link  [MAX_WORDS];
    t_byte                        hist_link [MAX_WORDS];

    // Clamp the registers into their working ranges
    always_comb begin
        if (r_word_length == '0) begin
            wl = t_wl'(1);
        end else if (r_word_length > t_cfg'(MAX_WORD_LEN)) begin
            wl = t_wl'(MAX_WORD_LEN);
        end else begin
            wl = r_word_length;
        end
        if (r_word_count == '0) begin
            wc = WC_W'(1);
        end else if ({1'b0, r_word_count} > 5'(MAX_WORDS)) begin
            wc = WC_W'(MAX_WORDS);
        end else begin
            wc = WC_W'(r_word_count);
        end
    end

    assign total = SEEN_W'(32'(wl) * 32'(wc));

    assign accept      = i_req.valid && i_req.ready;
    assign text_req    = accept && i_req.cmd == CMD_TEXT;
    assign load_req    = accept && i_req.cmd == CMD_LOAD;
    assign n_seen      = (r_seen < SEEN_W'(WIN)) ? r_seen + SEEN_W'(1) : r_seen;
    assign window_full = n_seen >= total;
    assign post        = r_state == ST_EMIT && (!r_ov || o_rsp.ready);

    assign ctrl.shift = text_req;
    assign ctrl.load  = text_req && window_full;
    assign ctrl.step  = r_state == ST_SCAN;
    assign ctrl.wl    = wl;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= t_cfg'(1);
            r_word_count  <= t_cfg'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WORD_LENGTH: r_word_length <= i_cfg_data;
                REG_WORD_COUNT:  r_word_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequence requests: take one, scan the window, post a hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_seen  <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_req.cmd == CMD_START) begin
                        r_pos  <= '0;
                        r_seen <= '0;
                    end else if (text_req) begin
                        r_pos  <= r_pos + t_pos'(1);
                        r_seen <= n_seen;
                        r_step <= '0;
                        if (window_full) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!found) begin
                        r_state <= ST_IDLE;
                    end else if (r_step == wc - WC_W'(1)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_step <= r_step + WC_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (post) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold the window start of the byte being checked
    always_ff @(posedge i_clk) begin
        if (text_req) begin
            r_start <= r_pos + t_pos'(1) - t_pos'(total);
        end
    end

    // Result register: post a hit, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (post) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (post) begin
            r_match_start <= r_start;
        end
    end

    assign i_req.ready       = r_state == ST_IDLE;
    assign o_rsp.valid       = r_ov;
    assign o_rsp.match_start = r_match_start;

    // Chain of window cells, newest bytes in cell 0
    for (genvar c = 0; c < MAX_WORDS; c++) begin : g_cell
        t_byte                        hist_in;
        logic [MAX_WORD_LEN-1:0][7:0] scr_in;

        assign hist_in = (c == 0) ? i_req.text_char : hist_link[(c == 0) ? 0 : c - 1];
        assign scr_in  = (c == MAX_WORDS - 1) ? '0
                                              : scr_link[(c == MAX_WORDS - 1) ? c : c + 1];

        wcm_cell #(
            .LEN (MAX_WORD_LEN)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_hist_prev (hist_in),
            .o_hist_last (hist_link[c]),
            .i_scr_next  (scr_in),
            .o_scr       (scr_link[c])
        );
    end

    wcm_match #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .WC_W         (WC_W)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (load_req),
        .i_slot  (i_req.word_slot),
        .i_chars (i_req.word_chars),
        .i_ctrl  (ctrl),
        .i_wc    (wc),
        .i_head  (scr_link[0]),
        .o_found (found)
    );

    // Byte count never passes the window capacity
    a_seen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(WIN))
        else $error("byte count beyond window capacity");

    // A hit is posted only right after a scan
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_EMIT) |-> $past(r_state) == ST_SCAN)
        else $error("post state entered without a scan");

    // A text byte that leaves the window short starts no scan
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (text_req && !window_full) |=> r_state == ST_IDLE)
        else $error("scan started on a short window");

endmodule

### rtl/wcm_cell.sv
// One window cell: LEN bytes of text history and LEN bytes of scratch.
// History moves one byte per text request; scratch moves wl bytes per step.
// Depends on wcm_pkg.
module wcm_cell import wcm_pkg::*; #(
    parameter int LEN = 8
) (
    input  logic                  i_clk,
    input  t_seq_ctrl             i_ctrl,
    input  t_byte                 i_hist_prev,   // oldest byte of the newer neighbor
    output t_byte                 o_hist_last,   // oldest byte held here
    input  logic [LEN-1:0][7:0]   i_scr_next,    // scratch of the older neighbor
    output logic [LEN-1:0][7:0]   o_scr
);

    localparam int IDX_W = $clog2(2 * LEN);

    logic [LEN-1:0][7:0]   r_hist;
    logic [LEN-1:0][7:0]   n_hist;
    logic [LEN-1:0][7:0]   r_scr;
    logic [LEN-1:0][7:0]   n_scr;
    logic [2*LEN-1:0][7:0] scr_ext;

    // Age every byte by one: slot 0 takes the neighbor's oldest byte
    always_comb begin
        n_hist[0] = i_hist_prev;
        for (int s = 1; s < LEN; s++) begin
            n_hist[s] = r_hist[s-1];
        end
    end

    // Drop one word from the near end: slot s takes distance s + wl
    assign scr_ext = {i_scr_next, r_scr};
    always_comb begin
        for (int s = 0; s < LEN; s++) begin
            n_scr[s] = scr_ext[IDX_W'(s) + IDX_W'(i_ctrl.wl)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_hist <= n_hist;
        end
        if (i_ctrl.load) begin
            r_scr <= n_hist;
        end else if (i_ctrl.step) begin
            r_scr <= n_scr;
        end
    end

    assign o_hist_last = r_hist[LEN-1];
    assign o_scr       = r_scr;

endmodule

### rtl/wcm_match.sv
// Dictionary slots and the greedy multiset matcher.
// Each step pairs the head window word with the lowest unused equal slot.
// Depends on wcm_pkg.
module wcm_match import wcm_pkg::*; #(
    parameter int MAX_WORDS    = 8,
    parameter int MAX_WORD_LEN = 8,
    parameter int WC_W         = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  t_slot                         i_slot,
    input  t_word                         i_chars,
    input  t_seq_ctrl                     i_ctrl,
    input  logic [WC_W-1:0]               i_wc,
    input  logic [MAX_WORD_LEN-1:0][7:0]  i_head,  // scratch head, newest byte first
    output logic                          o_found
);

    localparam int SEL_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    t_word                r_dict [MAX_WORDS];
    logic [MAX_WORDS-1:0] r_used;
    logic [7:0][7:0]      word;
    logic [7:0][7:0]      mask;
    logic [MAX_WORDS-1:0] eq;
    logic [MAX_WORDS-1:0] cand;
    logic [MAX_WORDS-1:0] pick;

    // Assemble the head word: byte b sits at distance wl-1-b from the head
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            word[b] = '0;
            mask[b] = '0;
            if (b < MAX_WORD_LEN && t_wl'(b) < i_ctrl.wl) begin
                word[b] = i_head[SEL_W'(int'(i_ctrl.wl) - 1 - b)];
                mask[b] = 8'hFF;
            end
        end
    end

    // Compare against all slots in use, skip those already paired
    always_comb begin
        for (int j = 0; j < MAX_WORDS; j++) begin
            eq[j]   = ((r_dict[j] ^ word) & mask) == '0;
            cand[j] = eq[j] && !r_used[j] && (WC_W'(j) < i_wc);
        end
        pick = cand & (~cand + MAX_WORDS'(1));
    end

    assign o_found = |cand;

    // Write dictionary slots; slots beyond the table are dropped
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_WORDS; j++) begin
            if (i_wr && int'(i_slot) == j) begin
                r_dict[j] <= i_chars;
            end
        end
    end

    // Track paired slots over one scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctrl.load) begin
            r_used <= '0;
        end else if (i_ctrl.step) begin
            r_used <= r_used | pick;
        end
    end

endmodule

### tb/wcm_window_check.sv
`timescale 1ns / 1ps
// Watches the request, result and register ports of the word concatenation matcher.
// It keeps its own copy of the window and dictionary and checks every match position.
// Depends on wcm_pkg, wcm_req_if and wcm_rsp_if.
module wcm_window_check import wcm_pkg::*; #(
    parameter int MAX_WORDS    = 8,
    parameter int MAX_WORD_LEN = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    wcm_req_if       req,
    wcm_rsp_if       rsp,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_cfg     i_cfg_data,
    output int       o_fail_count,
    output int       o_pending
);

    localparam int WIN_BYTES  = MAX_WORDS * MAX_WORD_LEN;
    localparam int FIFO_DEPTH = 64;

    t_word      dict_words [MAX_WORDS];
    t_byte      history [WIN_BYTES];
    t_pos       next_pos;
    logic [6:0] seen_count;
    t_cfg       word_length_reg;
    t_cfg       word_count_reg;
    t_pos       start_fifo [FIFO_DEPTH];
    int         fifo_wr;
    int         fifo_rd;

    always @(posedge i_clk) begin
        int    wl, wc, total, n_win, n_dict;
        t_pos  here;
        t_pos  got;
        t_word mask;
        t_word cut [MAX_WORDS];
        logic  hit;

        if (!i_rst_n) begin
            foreach (dict_words[i]) dict_words[i] = '0;
            foreach (history[i]) history[i] = '0;
            next_pos        = '0;
            seen_count      = '0;
            word_length_reg = 4'd1;
            word_count_reg  = 4'd1;
            fifo_wr         = 0;
            fifo_rd         = 0;
            o_fail_count    = 0;
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WORD_LENGTH: word_length_reg = i_cfg_data;
                    REG_WORD_COUNT:  word_count_reg  = i_cfg_data;
                    default: ;
                endcase
            end

            // Predict the outcome of an accepted request
            if (req.valid && req.ready) begin
                case (req.cmd)
                    CMD_LOAD: dict_words[req.word_slot] = req.word_chars;
                    CMD_START: begin
                        foreach (history[i]) history[i] = '0;
                        next_pos   = '0;
                        seen_count = '0;
                    end
                    CMD_TEXT: begin
                        wl = (word_length_reg == '0) ? 1 :
                             (int'(word_length_reg) > MAX_WORD_LEN) ? MAX_WORD_LEN :
                             int'(word_length_reg);
                        wc = (word_count_reg == '0) ? 1 :
                             (int'(word_count_reg) > MAX_WORDS) ? MAX_WORDS :
                             int'(word_count_reg);
                        total = wl * wc;
                        here  = next_pos;
                        for (int i = 0; i < WIN_BYTES - 1; i++) history[i] = history[i + 1];
                        history[WIN_BYTES - 1] = req.text_char;
                        if (seen_count < WIN_BYTES) seen_count = seen_count + 7'd1;
                        next_pos = next_pos + 16'd1;

                        // Cut the window into words and compare word multiplicities
                        if (int'(seen_count) >= total) begin
                            mask = (wl >= 8) ? {64{1'b1}} : (t_word'(1) << (8 * wl)) - t_word'(1);
                            for (int i = 0; i < wc; i++) begin
                                cut[i] = '0;
                                for (int b = 0; b < wl; b++)
                                    cut[i] |= t_word'(history[WIN_BYTES - total + i * wl + b])
                                              << (8 * b);
                            end
                            hit = 1'b1;
                            for (int i = 0; i < wc; i++) begin
                                n_win  = 0;
                                n_dict = 0;
                                for (int j = 0; j < wc; j++) begin
                                    if (cut[j] == cut[i]) n_win++;
                                    if ((dict_words[j] & mask) == cut[i]) n_dict++;
                                end
                                if (n_win != n_dict) hit = 1'b0;
                            end
                            // Queue the expected start position
                            if (hit) begin
                                start_fifo[fifo_wr % FIFO_DEPTH] =
                                    t_pos'(int'(here) + 65536 - total + 1);
                                fifo_wr++;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // Compare each result with the oldest expected position
            if (rsp.valid && rsp.ready) begin
                if (fifo_wr == fifo_rd) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] unexpected match result: match_start %h",
                                 $realtime, rsp.match_start);
                end else begin
                    got = start_fifo[fifo_rd % FIFO_DEPTH];
                    fifo_rd++;
                    if (rsp.match_start !== got) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("[%0t] match_start mismatch: expected %h, got %h",
                                     $realtime, got, rsp.match_start);
                    end
                end
            end
        end
        o_pending = fifo_wr - fifo_rd;
    end

endmodule

### tb/word_concatenation_matcher_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the word concatenation matcher top level.
// Depends on wcm_pkg, the channel interfaces, the block itself and wcm_window_check.
module word_concatenation_matcher_top_tb;
    import wcm_pkg::*;

    localparam t_cmd CMD_UNUSED = 2'd3;

    logic     i_clk;
    logic     i_rst_n;
    logic     cfg_we;
    t_cfg_idx cfg_idx;
    t_cfg     cfg_data;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       fail_count;
    int       pending;

    wcm_req_if req_if ();
    wcm_rsp_if rsp_if ();

    word_concatenation_matcher_top #(
        .MAX_WORDS    (8),
        .MAX_WORD_LEN (8)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    wcm_window_check #(
        .MAX_WORDS    (8),
        .MAX_WORD_LEN (8)
    ) u_window_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Stall the result side at random
    initial rsp_if.ready = 1'b0;
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("** word_concatenation_matcher_top: FAILED **");
        $finish;
    end

    function automatic int clamp_size(input t_cfg raw, input int hi);
        if (raw == '0) return 1;
        if (int'(raw) > hi) return hi;
        return int'(raw);
    endfunction

    // Keep the low bytes of core, fill the rest with random bytes
    function automatic t_word dress_word(input t_word core, input t_word keep);
        t_word noise;
        noise = {$urandom(), $urandom()};
        return (core & keep) | (noise & ~keep);
    endfunction

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input t_cmd cmd, input t_slot slot, input t_word chars,
                                input t_byte ch);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.word_slot  <= slot;
        req_if.word_chars <= chars;
        req_if.text_char  <= ch;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Drop valid, wait for every expected result, then let the scan settle
    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_config(input t_cfg wl_raw, input t_cfg wc_raw);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_WORD_LENGTH;
        cfg_data <= wl_raw;
        @(negedge i_clk);
        cfg_idx  <= REG_WORD_COUNT;
        cfg_data <= wc_raw;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        t_word dict_copy [8];
        t_word pool [3];
        int    order [8];
        int    wl, wc, pool_size, phase_items, pick, tmp, r;
        t_cfg  wl_raw, wc_raw;
        t_word low_mask;

        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = REG_WORD_LENGTH;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_LOAD;
        req_if.word_slot  = '0;
        req_if.word_chars = '0;
        req_if.text_char  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every slot first so no scan ever reads an unwritten one
        dict_copy[0] = 64'hFFFF_FFFF_FFFF_FF41;
        dict_copy[1] = '0;
        dict_copy[2] = {64{1'b1}};
        for (int s = 3; s < 8; s++) dict_copy[s] = {$urandom(), $urandom()};
        for (int s = 0; s < 8; s++) send_request(CMD_LOAD, t_slot'(s), dict_copy[s], 8'h00);

        // Single-byte window: one hit, two misses, unused command, restart, another hit
        send_request(CMD_TEXT, 3'd0, '0, 8'h41);
        send_request(CMD_TEXT, 3'd0, '0, 8'h00);
        send_request(CMD_TEXT, 3'd0, '0, 8'hFF);
        send_request(CMD_UNUSED, 3'd7, {64{1'b1}}, 8'hFF);
        send_request(CMD_START, 3'd0, '0, 8'h00);
        send_request(CMD_TEXT, 3'd0, '0, 8'h41);

        // Out-of-range registers clamp to one-byte words, eight per window
        drain_results();
        set_config(4'd0, 4'd15);
        send_request(CMD_START, 3'd0, '0, 8'h00);
        for (int s = 7; s >= 0; s--) send_request(CMD_TEXT, 3'd0, '0, dict_copy[s][7:0]);

        // Random phases: mostly shuffled dictionary concatenations plus noise
        for (int phase = 0; phase < 16; phase++) begin
            drain_results();
            case (phase)
                0: begin wl_raw = 4'd8;  wc_raw = 4'd8;  end
                1: begin wl_raw = 4'd15; wc_raw = 4'd0;  end
                2: begin wl_raw = 4'd1;  wc_raw = 4'd1;  end
                3: begin wl_raw = 4'd0;  wc_raw = 4'd0;  end
                default: begin
                    wl_raw = ($urandom_range(7) == 0) ? t_cfg'($urandom_range(15))
                                                      : t_cfg'($urandom_range(1, 8));
                    wc_raw = ($urandom_range(7) == 0) ? t_cfg'($urandom_range(15))
                                                      : t_cfg'($urandom_range(1, 8));
                end
            endcase
            set_config(wl_raw, wc_raw);
            wl = clamp_size(wl_raw, 8);
            wc = clamp_size(wc_raw, 8);
            low_mask = (wl >= 8) ? {64{1'b1}} : (t_word'(1) << (8 * wl)) - t_word'(1);

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase

            // Build the dictionary from a small pool so words repeat
            pool_size = $urandom_range(1, 3);
            for (int p = 0; p < pool_size; p++) pool[p] = {$urandom(), $urandom()};
            phase_items = 0;
            for (int s = 0; s < wc; s++) begin
                dict_copy[s] = dress_word(pool[$urandom_range(pool_size - 1)], low_mask);
                send_request(CMD_LOAD, t_slot'(s), dict_copy[s], t_byte'($urandom()));
                phase_items++;
            end
            if (wc < 8) begin
                pick = $urandom_range(7, wc);
                dict_copy[pick] = {$urandom(), $urandom()};
                send_request(CMD_LOAD, t_slot'(pick), dict_copy[pick], t_byte'($urandom()));
                phase_items++;
            end
            if ($urandom_range(1) == 1) begin
                send_request(CMD_START, t_slot'($urandom()), {$urandom(), $urandom()},
                             t_byte'($urandom()));
                phase_items++;
            end

            while (phase_items < 100) begin
                r = $urandom_range(99);
                if (r < 78) begin
                    // Send all words once, in shuffled order
                    for (int i = 0; i < wc; i++) order[i] = i;
                    for (int i = wc - 1; i > 0; i--) begin
                        pick     = $urandom_range(i);
                        tmp      = order[i];
                        order[i] = order[pick];
                        order[pick] = tmp;
                    end
                    for (int i = 0; i < wc; i++) begin
                        for (int b = 0; b < wl; b++) begin
                            send_request(CMD_TEXT, t_slot'($urandom()), {$urandom(), $urandom()},
                                         dict_copy[order[i]][8 * b +: 8]);
                            phase_items++;
                        end
                    end
                end else if (r < 90) begin
                    send_request(CMD_TEXT, t_slot'($urandom()), {$urandom(), $urandom()},
                                 t_byte'($urandom()));
                    phase_items++;
                end else if (r < 94) begin
                    // Reload a slot mid-text; slots in use stay drawn from the pool
                    pick = $urandom_range(7);
                    if (pick < wc)
                        dict_copy[pick] = dress_word(pool[$urandom_range(pool_size - 1)],
                                                     low_mask);
                    else
                        dict_copy[pick] = {$urandom(), $urandom()};
                    send_request(CMD_LOAD, t_slot'(pick), dict_copy[pick], t_byte'($urandom()));
                    phase_items++;
                end else if (r < 97) begin
                    send_request(CMD_START, t_slot'($urandom()), {$urandom(), $urandom()},
                                 t_byte'($urandom()));
                    phase_items++;
                end else begin
                    send_request(CMD_UNUSED, t_slot'($urandom()), {$urandom(), $urandom()},
                                 t_byte'($urandom()));
                end
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("** word_concatenation_matcher_top: PASSED **");
        else
            $display("** word_concatenation_matcher_top: FAILED **");
        $finish;
    end

endmodule
